FILE: src/ueoa_pkg.sv
// ueoa_pkg: shared types and constants for the ultrasonic echo obstacle avoider.
// No dependencies.
package ueoa_pkg;

	localparam int RANGE_BITS = 11;
	localparam int SPEED_BITS = 16;
	localparam int STAMP_IN_BITS = 16;

	// sensor select codes
	localparam logic [1:0] SENS_FRONT = 2'd0;
	localparam logic [1:0] SENS_LEFT  = 2'd1;
	localparam logic [1:0] SENS_RIGHT = 2'd2;
	localparam int SENSORS = 3;

	// register indexes
	localparam logic [1:0] REG_NEAR   = 2'd0;
	localparam logic [1:0] REG_CLEAR  = 2'd1;
	localparam logic [1:0] REG_CRUISE = 2'd2;
	localparam logic [1:0] REG_TURN   = 2'd3;

	localparam logic [RANGE_BITS-1:0] NEAR_RESET   = 11'd20;
	localparam logic [RANGE_BITS-1:0] CLEAR_RESET  = 11'd25;
	localparam logic [SPEED_BITS-1:0] CRUISE_RESET = 16'd500;
	localparam logic [SPEED_BITS-1:0] TURN_RESET   = 16'd300;

	// width/58 = (width/2)/29; 29 via reciprocal, exact for 16-bit numerators
	localparam int US_PER_CM = 58;
	localparam int DIV_SHIFT = 20;
	localparam logic [15:0] DIV_RECIP = 16'd36158;
	localparam logic [32:0] RANGE_SAT_US = 33'(2048 * US_PER_CM);
	localparam logic [RANGE_BITS-1:0] RANGE_MAX = 11'h7FF;

	typedef enum logic [1:0] {
		MODE_FORWARD = 2'd0,
		MODE_LEFT    = 2'd1,
		MODE_RIGHT   = 2'd2,
		MODE_STOP    = 2'd3
	} mode_t;

	localparam logic [3:0] PINS_FORWARD = 4'h5;
	localparam logic [3:0] PINS_LEFT    = 4'h9;
	localparam logic [3:0] PINS_RIGHT   = 4'h6;
	localparam logic [3:0] PINS_STOP    = 4'h0;

	typedef struct packed {
		mode_t                 mode;
		logic [3:0]            pins;
		logic [SPEED_BITS-1:0] left_speed;
		logic [SPEED_BITS-1:0] right_speed;
	} drive_t;

endpackage

FILE: src/ueoa_range.sv
// ueoa_range: echo pulse width to centimetres, modular stamp difference then /58.
// Depends on ueoa_pkg.
module ueoa_range #(
	parameter int STAMP_BITS = 16
) (
	input  logic [ueoa_pkg::STAMP_IN_BITS-1:0] stamp,
	input  logic [ueoa_pkg::STAMP_IN_BITS-1:0] rise,
	output logic [ueoa_pkg::RANGE_BITS-1:0]    range_cm
);
	import ueoa_pkg::*;

	logic [STAMP_BITS-1:0] fall_t, rise_t, width;
	logic [32:0]           width_x;
	logic [15:0]           half;
	logic [31:0]           prod;

	always_comb begin
		fall_t  = STAMP_BITS'(stamp);
		rise_t  = STAMP_BITS'(rise);
		width   = fall_t - rise_t;
		width_x = 33'(width);
		half    = width_x[16:1];
		prod    = 32'(half) * 32'(DIV_RECIP);
		if (width_x >= RANGE_SAT_US) begin
			range_cm = RANGE_MAX;
		end else begin
			range_cm = prod[DIV_SHIFT+RANGE_BITS-1:DIV_SHIFT];
		end
	end

endmodule

FILE: src/ueoa_drive.sv
// ueoa_drive: drive decision from the three ranges and the limit/speed registers.
// Depends on ueoa_pkg.
module ueoa_drive (
	input  logic [ueoa_pkg::RANGE_BITS-1:0] front,
	input  logic [ueoa_pkg::RANGE_BITS-1:0] left,
	input  logic [ueoa_pkg::RANGE_BITS-1:0] right,
	input  logic [ueoa_pkg::RANGE_BITS-1:0] near_limit,
	input  logic [ueoa_pkg::RANGE_BITS-1:0] clear_limit,
	input  logic [ueoa_pkg::SPEED_BITS-1:0] cruise,
	input  logic [ueoa_pkg::SPEED_BITS-1:0] turn,
	output ueoa_pkg::drive_t                drive
);
	import ueoa_pkg::*;

	always_comb begin
		priority if (front != '0 && front <= near_limit) begin
			if (left > clear_limit || right > clear_limit) begin
				if (left > right) begin
					drive.mode = MODE_LEFT;
					drive.pins = PINS_LEFT;
				end else begin
					drive.mode = MODE_RIGHT;
					drive.pins = PINS_RIGHT;
				end
				drive.left_speed  = turn;
				drive.right_speed = turn;
			end else begin
				drive.mode        = MODE_STOP;
				drive.pins        = PINS_STOP;
				drive.left_speed  = '0;
				drive.right_speed = '0;
			end
		end else begin
			drive.mode        = MODE_FORWARD;
			drive.pins        = PINS_FORWARD;
			drive.left_speed  = cruise;
			drive.right_speed = cruise;
		end
	end

endmodule

FILE: src/ultrasonic_echo_obstacle_avoider.sv
// ultrasonic_echo_obstacle_avoider: three-sensor echo ranging with drive decision.
// Depends on ueoa_pkg, ueoa_range, ueoa_drive.
// Request goes to the input register, then the result register; later while stalled.
// Throughput: one request per unstalled cycle; input register, one pass, result register.
// Reset: sensors wait for a rising edge, ranges zero, registers to defaults.
module ultrasonic_echo_obstacle_avoider #(
	parameter int STAMP_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// capture events
	input  logic                                ev_valid,
	output logic                                ev_stall,
	input  logic [1:0]                          sensor_sel,
	input  logic [ueoa_pkg::STAMP_IN_BITS-1:0]  stamp,
	// results
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                measure_done,
	output logic [ueoa_pkg::RANGE_BITS-1:0]     measured_cm,
	output logic [1:0]                          drive_mode,
	output logic [3:0]                          bridge_pins,
	output logic [ueoa_pkg::SPEED_BITS-1:0]     left_speed,
	output logic [ueoa_pkg::SPEED_BITS-1:0]     right_speed,
	// APB
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import ueoa_pkg::*;

	logic [RANGE_BITS-1:0] near_q, clear_q;
	logic [SPEED_BITS-1:0] cruise_q, turn_q;

	logic                     valid_s1;
	logic [1:0]               sel_s1;
	logic [STAMP_IN_BITS-1:0] stamp_s1;

	logic                     awaiting_q [SENSORS];
	logic [STAMP_IN_BITS-1:0] rise_q     [SENSORS];
	logic [RANGE_BITS-1:0]    range_q    [SENSORS];
	logic [RANGE_BITS-1:0]    range_n    [SENSORS];

	logic                     adv, fire, sel_ok, done_n;
	logic [1:0]               sidx;
	logic [STAMP_IN_BITS-1:0] rise_sel;
	logic [RANGE_BITS-1:0]    new_cm, meas_n;
	drive_t                   drive;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= NEAR_RESET;
			clear_q  <= CLEAR_RESET;
			cruise_q <= CRUISE_RESET;
			turn_q   <= TURN_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_NEAR:   near_q   <= pwdata[RANGE_BITS-1:0];
				REG_CLEAR:  clear_q  <= pwdata[RANGE_BITS-1:0];
				REG_CRUISE: cruise_q <= pwdata[SPEED_BITS-1:0];
				REG_TURN:   turn_q   <= pwdata[SPEED_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NEAR:   prdata = 32'(near_q);
			REG_CLEAR:  prdata = 32'(clear_q);
			REG_CRUISE: prdata = 32'(cruise_q);
			REG_TURN:   prdata = 32'(turn_q);
		endcase
	end

	// handshake
	assign adv      = !res_valid || !res_stall;
	assign fire     = valid_s1 && adv;
	assign ev_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ev_stall) begin
			valid_s1 <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && !ev_stall) begin
			sel_s1   <= sensor_sel;
			stamp_s1 <= stamp;
		end
	end

	// per-event processing
	assign sel_ok   = sel_s1 != 2'd3;
	assign sidx     = sel_ok ? sel_s1 : SENS_FRONT;
	assign rise_sel = rise_q[sidx];

	ueoa_range #(
		.STAMP_BITS(STAMP_BITS)
	) u_range (
		.stamp   (stamp_s1),
		.rise    (rise_sel),
		.range_cm(new_cm)
	);

	always_comb begin
		for (int i = 0; i < SENSORS; i++) begin
			range_n[i] = (sel_ok && sel_s1 == 2'(i) && awaiting_q[i]) ? new_cm : range_q[i];
		end
		done_n = sel_ok && awaiting_q[sidx];
		meas_n = sel_ok ? range_n[sidx] : '0;
	end

	ueoa_drive u_drive (
		.front      (range_n[SENS_FRONT]),
		.left       (range_n[SENS_LEFT]),
		.right      (range_n[SENS_RIGHT]),
		.near_limit (near_q),
		.clear_limit(clear_q),
		.cruise     (cruise_q),
		.turn       (turn_q),
		.drive      (drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSORS; i++) begin
				awaiting_q[i] <= 1'b0;
				rise_q[i]     <= '0;
				range_q[i]    <= '0;
			end
		end else if (fire && sel_ok) begin
			awaiting_q[sidx] <= !awaiting_q[sidx];
			range_q[sidx]    <= range_n[sidx];
			if (!awaiting_q[sidx]) begin
				rise_q[sidx] <= stamp_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			measure_done <= done_n;
			measured_cm  <= meas_n;
			drive_mode   <= drive.mode;
			bridge_pins  <= drive.pins;
			left_speed   <= drive.left_speed;
			right_speed  <= drive.right_speed;
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		ev_stall |-> valid_s1 && res_valid && res_stall)
		else $error("event stalled with no pending item");

	a_front_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sel_s1 == SENS_FRONT |=> awaiting_q[0] != $past(awaiting_q[0]))
		else $error("front edge phase did not toggle");

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && drive_mode == MODE_STOP |-> left_speed == '0 && right_speed == '0
			&& bridge_pins == PINS_STOP)
		else $error("stop with motors driven");

	a_done_on_fall: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sel_s1 == SENS_LEFT && !awaiting_q[1] |=> !measure_done)
		else $error("measurement flagged on a rising edge");

endmodule

FILE: bench/tb_ultrasonic_echo_obstacle_avoider.sv
`timescale 1ns / 1ps
// tb_ultrasonic_echo_obstacle_avoider: self-checking bench for echo ranging and steering.
// Predicts each result from the capture requests and the APB limits, then checks it.
// Depends on ueoa_pkg and ultrasonic_echo_obstacle_avoider.
module tb_ultrasonic_echo_obstacle_avoider;
	import ueoa_pkg::*;

	typedef struct {
		logic [1:0]  sel;
		logic [15:0] stamp;
	} capture_t;

	typedef struct {
		logic                  done;
		logic [RANGE_BITS-1:0] cm;
		mode_t                 mode;
		logic [3:0]            pins;
		logic [SPEED_BITS-1:0] lspd;
		logic [SPEED_BITS-1:0] rspd;
	} steer_t;

	localparam logic [1:0] SENS_NONE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  ev_valid = 1'b0;
	logic                  ev_stall;
	logic [1:0]            sensor_sel = 2'd0;
	logic [15:0]           stamp = 16'd0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic                  measure_done;
	logic [RANGE_BITS-1:0] measured_cm;
	logic [1:0]            drive_mode;
	logic [3:0]            bridge_pins;
	logic [SPEED_BITS-1:0] left_speed;
	logic [SPEED_BITS-1:0] right_speed;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [3:0]            paddr = 4'd0;
	logic [31:0]           pwdata = 32'd0;
	logic [31:0]           prdata;
	logic                  pready;

	ultrasonic_echo_obstacle_avoider u_dut (.*);

	// predictor state
	logic                  echo_high [SENSORS] = '{default: 1'b0};
	logic [15:0]           echo_rise [SENSORS] = '{default: 16'd0};
	logic [RANGE_BITS-1:0] echo_cm [SENSORS] = '{default: '0};
	logic [RANGE_BITS-1:0] near_cm = NEAR_RESET;
	logic [RANGE_BITS-1:0] clear_cm = CLEAR_RESET;
	logic [SPEED_BITS-1:0] cruise_spd = CRUISE_RESET;
	logic [SPEED_BITS-1:0] turn_spd = TURN_RESET;

	// generator view of each sensor's edge parity
	logic gen_high [SENSORS] = '{default: 1'b0};

	capture_t capture_q[$];
	steer_t   steer_due[$];
	int       queued = 0;
	int       captures_taken = 0;
	int       results_checked = 0;
	int       mismatches = 0;
	int       mode_hits [4] = '{default: 0};
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string fname, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", fname, got, want));
	endtask

	function automatic void predict_capture(input logic [1:0] sel, input logic [15:0] st);
		steer_t                r;
		logic [15:0]           pulse_us;
		int                    q;
		logic [RANGE_BITS-1:0] f, l, rt;
		r.done = 1'b0;
		r.cm = '0;
		if (sel <= SENS_RIGHT) begin
			if (!echo_high[sel]) begin
				echo_rise[sel] = st;
				echo_high[sel] = 1'b1;
			end else begin
				pulse_us = st - echo_rise[sel];
				q = pulse_us / US_PER_CM;
				echo_cm[sel] = (q > RANGE_MAX) ? RANGE_MAX : RANGE_BITS'(q);
				echo_high[sel] = 1'b0;
				r.done = 1'b1;
			end
			r.cm = echo_cm[sel];
		end
		f = echo_cm[SENS_FRONT];
		l = echo_cm[SENS_LEFT];
		rt = echo_cm[SENS_RIGHT];
		if (f != 0 && f <= near_cm) begin
			if (l > clear_cm || rt > clear_cm) begin
				r.mode = (l > rt) ? MODE_LEFT : MODE_RIGHT;
				r.pins = (l > rt) ? PINS_LEFT : PINS_RIGHT;
				r.lspd = turn_spd;
				r.rspd = turn_spd;
			end else begin
				r.mode = MODE_STOP;
				r.pins = PINS_STOP;
				r.lspd = '0;
				r.rspd = '0;
			end
		end else begin
			r.mode = MODE_FORWARD;
			r.pins = PINS_FORWARD;
			r.lspd = cruise_spd;
			r.rspd = cruise_spd;
		end
		mode_hits[r.mode]++;
		steer_due.push_back(r);
	endfunction

	// capture request driver
	always @(posedge clk) begin : drive_captures
		capture_t nxt;
		if (arst_n) begin
			if (ev_valid && !ev_stall) begin
				predict_capture(sensor_sel, stamp);
				captures_taken++;
			end
			if (!ev_valid || !ev_stall) begin
				if (capture_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = capture_q.pop_front();
					ev_valid <= 1'b1;
					sensor_sel <= nxt.sel;
					stamp <= nxt.stamp;
				end else begin
					ev_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : watch_results
		steer_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				results_checked++;
				if (steer_due.size() == 0) begin
					report_mismatch("result with nothing outstanding");
				end else begin
					want = steer_due.pop_front();
					check_field("measure_done", measure_done, want.done);
					check_field("measured_cm", measured_cm, want.cm);
					check_field("drive_mode", drive_mode, want.mode);
					check_field("bridge_pins", bridge_pins, want.pins);
					check_field("left_speed", left_speed, want.lspd);
					check_field("right_speed", right_speed, want.rspd);
				end
			end
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value,
			input logic [31:0] mask);
		logic [31:0] rd;
		logic [31:0] wdata;
		wdata = ($urandom & ~mask) | (value & mask);
		case (idx)
			REG_NEAR:   near_cm = wdata[RANGE_BITS-1:0];
			REG_CLEAR:  clear_cm = wdata[RANGE_BITS-1:0];
			REG_CRUISE: cruise_spd = wdata[SPEED_BITS-1:0];
			REG_TURN:   turn_spd = wdata[SPEED_BITS-1:0];
		endcase
		apb_xfer(1'b1, idx, wdata, rd);
		apb_xfer(1'b0, idx, 32'd0, rd);
		check_field($sformatf("register %0d readback", idx), rd, wdata & mask);
	endtask

	task automatic set_limits(input logic [31:0] near, input logic [31:0] clear,
			input logic [31:0] cruise, input logic [31:0] turn);
		write_reg(REG_NEAR, near, 32'h7FF);
		write_reg(REG_CLEAR, clear, 32'h7FF);
		write_reg(REG_CRUISE, cruise, 32'hFFFF);
		write_reg(REG_TURN, turn, 32'hFFFF);
	endtask

	// drain everything in flight, then allow for the pipeline
	task automatic settle();
		while (capture_q.size() != 0 || ev_valid || steer_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_capture(input logic [1:0] sel, input logic [15:0] st);
		capture_t c;
		c.sel = sel;
		c.stamp = st;
		capture_q.push_back(c);
		queued++;
		if (sel <= SENS_RIGHT)
			gen_high[sel] = !gen_high[sel];
	endtask

	task automatic ready_sensor(input logic [1:0] sel);
		if (gen_high[sel])
			push_capture(sel, 16'($urandom));
	endtask

	task automatic push_pulse(input logic [1:0] sel, input logic [15:0] rise,
			input logic [15:0] width);
		ready_sensor(sel);
		push_capture(sel, rise);
		push_capture(sel, rise + width);
	endtask

	// echo widths clustered on the current limits, mixed with random widths
	function automatic logic [15:0] pulse_width();
		int cm;
		int us;
		case ($urandom_range(6))
			0: cm = 0;
			1: cm = int'(near_cm) - 1 + int'($urandom_range(2));
			2: cm = int'(clear_cm) - 1 + int'($urandom_range(2));
			3: cm = $urandom_range(1129);
			4: return 16'($urandom);
			default: cm = $urandom_range(60);
		endcase
		if (cm < 0)
			cm = 0;
		if (cm > 1129)
			cm = 1129;
		us = cm * US_PER_CM + int'($urandom_range(US_PER_CM - 1));
		return (us > 65535) ? 16'hFFFF : 16'(us);
	endfunction

	task automatic queue_random(input int n);
		int          goal;
		int          pick;
		logic [1:0]  s1, s2;
		logic [15:0] r1, r2, w1, w2;
		goal = queued + n;
		while (queued < goal) begin
			pick = $urandom_range(99);
			s1 = 2'($urandom_range(2));
			s2 = 2'((s1 + 1 + $urandom_range(1)) % 3);
			if (pick < 6) begin
				push_capture(SENS_NONE, 16'($urandom));
			end else if (pick < 14) begin
				push_capture(s1, 16'($urandom));
			end else if (pick < 40) begin
				r1 = 16'($urandom);
				r2 = 16'($urandom);
				w1 = pulse_width();
				w2 = pulse_width();
				ready_sensor(s1);
				ready_sensor(s2);
				push_capture(s1, r1);
				push_capture(s2, r2);
				push_capture(s1, r1 + w1);
				push_capture(s2, r2 + w2);
			end else begin
				push_pulse(s1, 16'($urandom), pulse_width());
			end
		end
	endtask

	initial begin : stimulus
		int p;
		wait (arst_n === 1'b1);
		repeat (3) @(negedge clk);

		// reset limits: near 20, clear 25
		push_capture(SENS_NONE, 16'hFFFF);
		push_pulse(SENS_FRONT, 16'h0000, 16'hFFFF);
		push_pulse(SENS_FRONT, 16'h1234, 16'h0000);
		push_pulse(SENS_FRONT, 16'hFFDC, 16'(10 * 58));
		push_pulse(SENS_LEFT, 16'd100, 16'(30 * 58));
		push_pulse(SENS_RIGHT, 16'd40000, 16'(30 * 58 + 57));
		push_pulse(SENS_RIGHT, 16'hAAAA, 16'(40 * 58));
		push_pulse(SENS_LEFT, 16'h5555, 16'(50 * 58));
		push_pulse(SENS_LEFT, 16'hFFFF, 16'(25 * 58 + 57));
		push_pulse(SENS_RIGHT, 16'h8000, 16'(25 * 58));
		push_pulse(SENS_FRONT, 16'h7FFF, 16'(20 * 58 + 57));
		push_pulse(SENS_FRONT, 16'h0001, 16'(21 * 58));
		push_capture(SENS_NONE, 16'h0000);

		for (p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: ;
				1: set_limits(32'd0, 32'd0, 32'd0, 32'd0);
				2: set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				3: set_limits(32'd1129, 32'd1129, $urandom, $urandom);
				default: set_limits($urandom_range(150), $urandom_range(150),
						$urandom, $urandom);
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			queue_random(210);
		end
		settle();

		$display("Checked %0d results from %0d capture requests across 8 limit settings",
				results_checked, captures_taken);
		$display("Decisions: forward %0d, left %0d, right %0d, stop %0d",
				mode_hits[MODE_FORWARD], mode_hits[MODE_LEFT],
				mode_hits[MODE_RIGHT], mode_hits[MODE_STOP]);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/ueoa_pkg.sv
src/ueoa_range.sv
src/ueoa_drive.sv
src/ultrasonic_echo_obstacle_avoider.sv
bench/tb_ultrasonic_echo_obstacle_avoider.sv
